>>> hw/rtl/lpfr_pkg.sv
// Package for the length-prefixed frame receiver.
// Sizes, phase and result codes, and the result bundle; no dependencies.
package lpfr_pkg;

	localparam int BUFFER_SIZE = 1024;
	localparam int HEADER_AND_CSUM = 9;
	localparam logic [31:0] LEN_LIMIT = 32'(BUFFER_SIZE - HEADER_AND_CSUM);
	localparam int CNT_W = $clog2(BUFFER_SIZE);
	localparam int OUT_W = 10;

	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_LEN  = 4'b0010,
		PH_DATA = 4'b0100,
		PH_CSUM = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_DROP    = 2'd2
	} kind_t;

	typedef struct packed {
		logic             valid;
		kind_t            kind;
		logic [7:0]       data;
		logic [OUT_W-1:0] offset;
		logic [OUT_W-1:0] length;
	} lpfr_result_t;

endpackage

>>> hw/rtl/lpfr_parser.sv
// Frame phase machine: hunt, length gather, payload pass-through, checksum skip.
// Uses lpfr_pkg; the result is combinational on the byte being transferred.
module lpfr_parser import lpfr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   rx_byte,
	input  logic [7:0]   start_byte,
	output lpfr_result_t res
);

	phase_t            phase_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       len_q;

	phase_t            phase_d;
	logic [CNT_W-1:0]  cnt_d;
	logic [31:0]       len_d;
	logic [CNT_W-1:0]  cnt_inc;
	logic [31:0]       len_gather;
	logic [31:0]       cnt_ext;

	assign cnt_inc    = cnt_q + 1'b1;
	assign len_gather = len_q | ({24'd0, rx_byte} << {cnt_q[1:0], 3'b000});
	assign cnt_ext    = 32'(cnt_q);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		len_d   = len_q;
		res     = '0;
		res.kind = KIND_PAYLOAD;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == start_byte) begin
					phase_d = PH_LEN;
					cnt_d   = '0;
					len_d   = '0;
				end
			end
			PH_LEN: begin
				len_d = len_gather;
				cnt_d = cnt_inc;
				if (cnt_q[1:0] == 2'd3) begin
					cnt_d = '0;
					if (len_gather > LEN_LIMIT) begin
						// oversize: drop and go back to hunting
						phase_d   = PH_HUNT;
						len_d     = '0;
						res.valid = 1'b1;
						res.kind  = KIND_DROP;
					end else if (len_gather == 32'd0) begin
						phase_d = PH_CSUM;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				res.valid  = 1'b1;
				res.kind   = KIND_PAYLOAD;
				res.data   = rx_byte;
				res.offset = cnt_ext[OUT_W-1:0];
				cnt_d      = cnt_inc;
				if (cnt_inc == len_q[CNT_W-1:0]) begin
					phase_d = PH_CSUM;
					cnt_d   = '0;
				end
			end
			PH_CSUM: begin
				cnt_d = cnt_inc;
				if (cnt_q[1:0] == 2'd3) begin
					res.valid  = 1'b1;
					res.kind   = KIND_DONE;
					res.length = len_q[OUT_W-1:0];
					phase_d    = PH_HUNT;
					cnt_d      = '0;
					len_d      = '0;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				cnt_d   = '0;
				len_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			len_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
		end
	end

endmodule

>>> hw/rtl/length_prefixed_frame_receiver_top.sv
// Top level of the length-prefixed frame receiver: config register, phase
// machine (lpfr_parser) and the result register. Uses lpfr_pkg.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    rx_byte
//  out      source     out_valid / out_ready  result_kind, payload_byte,
//                                             payload_offset, frame_length
//  cfg      sink       cfg_valid / cfg_ready  cfg_data (start byte)
//
// One byte per cycle while in_ready is high: the phase machine updates on the
// input transfer and its result is loaded into the output register by that same transfer.
// in_ready is high whenever the output register is empty or being drained, so
// a stalled consumer stalls the input only while a result is held.
// cfg_ready is always high. Reset clears phase, counters, start byte (to 0)
// and the output valid; no clearing pass.
module length_prefixed_frame_receiver_top import lpfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       result_kind,
	output logic [7:0]       payload_byte,
	output logic [OUT_W-1:0] payload_offset,
	output logic [OUT_W-1:0] frame_length,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);

	logic [7:0]   start_byte_q;
	logic         out_valid_q;
	lpfr_result_t res;
	lpfr_result_t res_q;
	logic         take;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= '0;
		end else if (cfg_valid) begin
			start_byte_q <= cfg_data;
		end
	end

	lpfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx_byte),
		.start_byte (start_byte_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload: load only when a new result is produced
	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = res_q.kind;
	assign payload_byte   = res_q.data;
	assign payload_offset = res_q.offset;
	assign frame_length   = res_q.length;

endmodule

>>> hw/rtl/lpfr_checker.sv
// Port-level checks for the length-prefixed frame receiver, bound to the top.
// Uses lpfr_pkg for the result codes.
module lpfr_checker import lpfr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [1:0]       result_kind,
	input logic [7:0]       payload_byte,
	input logic [OUT_W-1:0] payload_offset,
	input logic [OUT_W-1:0] frame_length
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind)
			&& $stable(payload_byte) && $stable(payload_offset) && $stable(frame_length))
		else $error("result changed while stalled");

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_kind == KIND_PAYLOAD || result_kind == KIND_DONE
			|| result_kind == KIND_DROP))
		else $error("illegal result kind");

	a_nonpayload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_PAYLOAD |-> payload_byte == 8'd0
			&& payload_offset == '0)
		else $error("payload fields set on a non-payload result");

	a_drop_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_DONE |-> frame_length == '0)
		else $error("frame length set on a result other than frame done");

endmodule

bind length_prefixed_frame_receiver_top lpfr_checker u_lpfr_checker (.*);

>>> dv/lpfr_frame_checker.sv
// Checker for the length-prefixed frame receiver: tracks the frame parser
// state from accepted bytes and start-byte writes, and compares every result
// transfer with the oldest predicted one. Uses lpfr_pkg.
module lpfr_frame_checker import lpfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [7:0]       rx_byte,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [1:0]       result_kind,
	input  logic [7:0]       payload_byte,
	input  logic [OUT_W-1:0] payload_offset,
	input  logic [OUT_W-1:0] frame_length,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [7:0]       cfg_data,
	output int               failures,
	output int               outstanding
);

	localparam int unsigned LEN_BYTES = 4;
	localparam int unsigned CSUM_BYTES = 4;
	localparam int REPORT_LIMIT = 10;

	phase_t       parse_phase;
	int unsigned  bytes_in_phase;
	logic [31:0]  gathered_len;
	logic [7:0]   sync_byte;
	lpfr_result_t results_due[$];

	assign outstanding = results_due.size();

	function automatic void queue_result(kind_t k, logic [7:0] d, logic [OUT_W-1:0] o,
			logic [OUT_W-1:0] l);
		lpfr_result_t r;
		r.valid = 1'b1;
		r.kind = k;
		r.data = d;
		r.offset = o;
		r.length = l;
		results_due.push_back(r);
	endfunction

	function automatic void restart_hunt();
		parse_phase = PH_HUNT;
		bytes_in_phase = 0;
		gathered_len = '0;
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		case (parse_phase)
			PH_HUNT: begin
				if (b == sync_byte) begin
					parse_phase = PH_LEN;
					bytes_in_phase = 0;
					gathered_len = '0;
				end
			end
			PH_LEN: begin
				// length arrives least significant byte first
				gathered_len = gathered_len | (32'(b) << (8 * bytes_in_phase));
				bytes_in_phase++;
				if (bytes_in_phase == LEN_BYTES) begin
					bytes_in_phase = 0;
					if (gathered_len > LEN_LIMIT) begin
						restart_hunt();
						queue_result(KIND_DROP, '0, '0, '0);
					end else begin
						parse_phase = (gathered_len == 0) ? PH_CSUM : PH_DATA;
					end
				end
			end
			PH_DATA: begin
				queue_result(KIND_PAYLOAD, b, OUT_W'(bytes_in_phase), '0);
				bytes_in_phase++;
				if (bytes_in_phase >= gathered_len) begin
					parse_phase = PH_CSUM;
					bytes_in_phase = 0;
				end
			end
			default: begin
				// checksum is skipped, never verified
				bytes_in_phase++;
				if (bytes_in_phase == CSUM_BYTES) begin
					queue_result(KIND_DONE, '0, '0, OUT_W'(gathered_len));
					restart_hunt();
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lpfr_result_t want;
		if (!arst_n) begin
			restart_hunt();
			sync_byte = '0;
			failures = 0;
			results_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					if (failures < REPORT_LIMIT)
						$display("%0t: unexpected result kind=%0d byte=%0h offset=%0d length=%0d",
							$realtime, result_kind, payload_byte, payload_offset, frame_length);
					failures++;
				end else begin
					want = results_due.pop_front();
					if (result_kind != want.kind || payload_byte != want.data ||
							payload_offset != want.offset || frame_length != want.length) begin
						if (failures < REPORT_LIMIT)
							$display("%0t: result mismatch kind %0d/%0d byte %0h/%0h offset %0d/%0d length %0d/%0d (expected/actual)",
								$realtime, want.kind, result_kind, want.data, payload_byte,
								want.offset, payload_offset, want.length, frame_length);
						failures++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_byte(rx_byte);
			// a new start byte takes effect from the next hunt
			if (cfg_valid && cfg_ready)
				sync_byte = cfg_data;
		end
	end

endmodule

>>> dv/length_prefixed_frame_receiver_top_test.sv
// Testbench top for the length-prefixed frame receiver: clock, reset, byte and
// start-byte stimulus, result consumer with random stalls, watchdog and verdict.
// Uses lpfr_pkg, length_prefixed_frame_receiver_top and lpfr_frame_checker.
module length_prefixed_frame_receiver_top_test;
	import lpfr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int unsigned RANDOM_ITEMS = 400;
	localparam int unsigned ITEMS_PER_SETTING = 70;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       rx_byte = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       result_kind;
	logic [7:0]       payload_byte;
	logic [OUT_W-1:0] payload_offset;
	logic [OUT_W-1:0] frame_length;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [7:0]       cfg_data = '0;

	int          failures;
	int          outstanding;
	int unsigned max_gap_in = 0;
	int unsigned max_gap_out = 0;
	int unsigned hold_requests = 0;
	int          stalled_cycles = 0;

	length_prefixed_frame_receiver_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.payload_byte   (payload_byte),
		.payload_offset (payload_offset),
		.frame_length   (frame_length),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	lpfr_frame_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.payload_byte   (payload_byte),
		.payload_offset (payload_offset),
		.frame_length   (frame_length),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.failures       (failures),
		.outstanding    (outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// keep valid high across back-to-back transfers
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = $urandom_range(0, max_gap_in);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_frame(input logic [7:0] sb, input logic [31:0] len,
			output int unsigned n);
		int unsigned noise;
		int unsigned i;
		logic [7:0]  b;
		noise = $urandom_range(0, 3);
		repeat (noise) begin
			b = 8'($urandom);
			if (b == sb)
				b = ~b;
			send_byte(b);
		end
		send_byte(sb);
		for (i = 0; i < 4; i++)
			send_byte(len[8*i +: 8]);
		n = 5;
		if (len <= LEN_LIMIT) begin
			for (i = 0; i < len; i++)
				send_byte(($urandom_range(0, 7) == 0) ? sb : 8'($urandom));
			repeat (4) send_byte(8'($urandom));
			n += len + 4;
		end
	endtask

	// drop valid and wait until every predicted result has been taken
	task automatic wait_quiet();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_start_byte(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_length();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 2))
					0: return LEN_LIMIT + 1;
					1: return $urandom | 32'h8000_0000;
					default: return $urandom_range(LEN_LIMIT + 1, 65535);
				endcase
			end
			1: return 0;
			2: return $urandom_range(25, 120);
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	function automatic int unsigned pick_gap_limit();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 19;
		endcase
	endfunction

	// result consumer
	initial begin
		int unsigned gap;
		int unsigned holds_served;
		holds_served = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_requests != holds_served) begin
				holds_served++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				gap = $urandom_range(0, max_gap_out);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		int unsigned random_items;
		int unsigned setting_items;
		int unsigned setting;
		logic [7:0]  sb;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start byte at its reset value: zero length, then an all-ones length
		send_frame(8'h00, 32'h0, n);
		send_frame(8'h00, 32'hFFFF_FFFF, n);
		// change the start byte halfway through a length field
		send_byte(8'h00);
		send_byte(8'h02);
		send_byte(8'h00);
		wait_quiet();
		load_start_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		repeat (4) send_byte(8'($urandom));
		send_frame(8'hFF, 32'h1, n);

		random_items = 0;
		for (setting = 0; random_items < RANDOM_ITEMS; setting++) begin
			wait_quiet();
			case (setting)
				0: sb = 8'h00;
				1: sb = 8'hFF;
				default: sb = 8'($urandom);
			endcase
			load_start_byte(sb);
			max_gap_in = pick_gap_limit();
			max_gap_out = pick_gap_limit();
			if (setting == 1) begin
				// keep offering bytes while the consumer holds off
				max_gap_in = 0;
				hold_requests++;
			end
			setting_items = 0;
			while (setting_items < ITEMS_PER_SETTING) begin
				send_frame(sb, pick_length(), n);
				setting_items += n;
			end
			random_items += setting_items;
		end

		wait_quiet();
		@(negedge clk);
		if (failures == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
